@@ rtl/ump_pkg.sv @@
// Package for the usage message parser: character codes, digit limits and
// the result record type. No dependencies.

package ump_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned RUN_W     = 2;
  localparam int unsigned USAGE_W   = 8;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [CHAR_W-1:0] END_MARK  = 8'h25;  // '%'
  localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_C    = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_P    = 8'h50;
  localparam logic [CHAR_W-1:0] CHAR_U    = 8'h55;
  localparam logic [CHAR_W-1:0] CHAR_R    = 8'h52;
  localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_M    = 8'h4D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  localparam logic [RUN_W-1:0] DIGIT_LIMIT = 2'd3;

  localparam logic CHAN_CPU = 1'b0;
  localparam logic CHAN_RAM = 1'b1;

  typedef struct packed {
    logic [USAGE_W-1:0] usage;
    logic               channel;
  } result_t;

endpackage

@@ rtl/usage_message_parser.sv @@
// Usage message parser top level: scans a byte stream for "CPU"/"RAM" usage
// reports ended by '%'. Depends on ump_pkg.

// Usage:
//   Bytes enter on the s_axis group, one per transaction. Each byte updates a
//   small set of message registers (count, last two characters, match flags,
//   trailing digits) in the cycle it is accepted. A '%' byte closes the
//   message: if "CPU" was seen the block emits a result on channel 0, else if
//   "RAM" was seen on channel 1, else nothing; the message is cleared.
//   A byte other than '%' that arrives while MAX_MSG_LEN characters are held
//   clears the message and is dropped.
//   Results leave on the m_axis group: tuser = channel, tdata =
//   usage (last up to three digits before '%', modulo 256).
//   Output: a result is registered into the output buffer when its '%' is accepted.
//   Throughput: one byte per cycle while s_axis_tready is high; the state update
//   and result formation are a single registered pass, so nothing else limits the rate below one.
//   Stall: a two-entry output buffer (result register plus skid register)
//   holds results while the receiver stalls; s_axis_tready drops only when
//   both entries are full.
//   Reset (rst, synchronous): clears the message state and empties the
//   output buffer.

module usage_message_parser #(
  parameter int unsigned MAX_MSG_LEN = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ump_pkg::CHAR_W-1:0]        s_axis_tdata,   // [7:0] rx_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ump_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [7:0] usage
  output logic                              m_axis_tuser    // [0] channel
);

  import ump_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_MSG_LEN + 1);
  localparam logic [CNT_W-1:0] MSG_FULL = CNT_W'(MAX_MSG_LEN);

  // Message state
  logic [CNT_W-1:0]   held_count, held_count_next;
  logic [CHAR_W-1:0]  recent0, recent0_next;
  logic [CHAR_W-1:0]  recent1, recent1_next;
  logic               cpu_found, cpu_found_next;
  logic               ram_found, ram_found_next;
  logic               text_ended, text_ended_next;
  logic [DIGIT_W-1:0] digit0, digit0_next;
  logic [DIGIT_W-1:0] digit1, digit1_next;
  logic [DIGIT_W-1:0] digit2, digit2_next;
  logic [RUN_W-1:0]   digit_run, digit_run_next;

  // Output buffer
  logic    out_valid, skid_valid;
  result_t out_data, skid_data;

  logic               accept, pop, push;
  logic [CHAR_W-1:0]  c;
  logic               is_digit;
  logic [USAGE_W-1:0] trailing;
  result_t            new_result;

  assign c             = s_axis_tdata;
  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign is_digit      = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

  // Trailing value: only the digits inside the current run count; wrap to 8 bits.
  always_comb begin
    trailing = '0;
    if (digit_run >= 2'd1) trailing = trailing + USAGE_W'(digit0);
    if (digit_run >= 2'd2) trailing = trailing + USAGE_W'(digit1) * USAGE_W'(10);
    if (digit_run >= 2'd3) trailing = trailing + USAGE_W'(digit2) * USAGE_W'(100);
  end

  // Next message state and result for the accepted byte
  always_comb begin
    held_count_next = held_count;
    recent0_next    = recent0;
    recent1_next    = recent1;
    cpu_found_next  = cpu_found;
    ram_found_next  = ram_found;
    text_ended_next = text_ended;
    digit0_next     = digit0;
    digit1_next     = digit1;
    digit2_next     = digit2;
    digit_run_next  = digit_run;
    push            = 1'b0;
    new_result.channel = cpu_found ? CHAN_CPU : CHAN_RAM;
    new_result.usage   = trailing;

    if (c == END_MARK || held_count >= MSG_FULL) begin
      // Close the message (or drop on overflow): report on '%' only, then clear.
      push            = (c == END_MARK) && (cpu_found || ram_found);
      held_count_next = '0;
      recent0_next    = '0;
      recent1_next    = '0;
      cpu_found_next  = 1'b0;
      ram_found_next  = 1'b0;
      text_ended_next = 1'b0;
      digit0_next     = '0;
      digit1_next     = '0;
      digit2_next     = '0;
      digit_run_next  = '0;
    end else begin
      // Name search stops at the first NUL byte.
      if (!text_ended) begin
        if (c == CHAR_NUL) begin
          text_ended_next = 1'b1;
        end else begin
          if (recent1 == CHAR_C && recent0 == CHAR_P && c == CHAR_U) cpu_found_next = 1'b1;
          if (recent1 == CHAR_R && recent0 == CHAR_A && c == CHAR_M) ram_found_next = 1'b1;
        end
      end
      recent1_next = recent0;
      recent0_next = c;
      if (is_digit) begin
        digit2_next = digit1;
        digit1_next = digit0;
        digit0_next = c[DIGIT_W-1:0];
        if (digit_run < DIGIT_LIMIT) digit_run_next = digit_run + 2'd1;
      end else begin
        digit_run_next = '0;
      end
      held_count_next = held_count + CNT_W'(1);
    end
  end

  // Message registers: advance on every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      recent0    <= '0;
      recent1    <= '0;
      cpu_found  <= 1'b0;
      ram_found  <= 1'b0;
      text_ended <= 1'b0;
      digit0     <= '0;
      digit1     <= '0;
      digit2     <= '0;
      digit_run  <= '0;
    end else if (accept) begin
      held_count <= held_count_next;
      recent0    <= recent0_next;
      recent1    <= recent1_next;
      cpu_found  <= cpu_found_next;
      ram_found  <= ram_found_next;
      text_ended <= text_ended_next;
      digit0     <= digit0_next;
      digit1     <= digit1_next;
      digit2     <= digit2_next;
      digit_run  <= digit_run_next;
    end
  end

  // Output buffer: result register in front, skid register behind it.
  // tready is low while the skid entry is full, so a push never meets two full entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept && push;
        end
      end else if (accept && push) begin
        if (!out_valid) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept && push) begin
        out_data <= new_result;
      end
    end else if (accept && push) begin
      if (!out_valid) begin
        out_data <= new_result;
      end else begin
        skid_data <= new_result;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data.usage;
  assign m_axis_tuser  = out_data.channel;

endmodule
